[rtl/lpg_pkg.sv]
// Package for the LED pattern generator: pattern codes, register indexes,
// configuration record type and reset values.
// No dependencies; every other file but lpg_checker imports it.
package lpg_pkg;

	// widths fixed by the register map and the pixel format
	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int INTERVAL_W = 16;
	localparam int MODE_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// pattern codes
	localparam logic [MODE_W-1:0] MODE_SOLID  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FAST   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd4;

	// register indexes on the write port
	localparam logic [REG_IDX_W-1:0] REG_MODE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_COLOR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PULSE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BLINK = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FAST  = 3'd4;

	// register reset values
	localparam logic [MODE_W-1:0]     RST_MODE  = MODE_PULSE;
	localparam logic [COLOR_W-1:0]    RST_COLOR = 24'h000000;
	localparam logic [INTERVAL_W-1:0] RST_PULSE = 16'd30;
	localparam logic [INTERVAL_W-1:0] RST_BLINK = 16'd500;
	localparam logic [INTERVAL_W-1:0] RST_FAST  = 16'd100;

	// saturation point of the tick counter
	localparam logic [INTERVAL_W-1:0] ELAPSED_MAX = 16'hFFFF;

	// configuration seen by the pattern logic
	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [COLOR_W-1:0]    color;
		logic [INTERVAL_W-1:0] pulse_int;
		logic [INTERVAL_W-1:0] blink_int;
		logic [INTERVAL_W-1:0] fast_int;
	} lpg_cfg_t;

endpackage

[rtl/lpg_regs.sv]
// Configuration register file of the LED pattern generator.
// Depends on lpg_pkg for register indexes, reset values and lpg_cfg_t.
module lpg_regs
	import lpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output lpg_cfg_t              cfg
);

	lpg_cfg_t cfg_q;

	// register writes, indexes beyond the map are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= RST_MODE;
			cfg_q.color     <= RST_COLOR;
			cfg_q.pulse_int <= RST_PULSE;
			cfg_q.blink_int <= RST_BLINK;
			cfg_q.fast_int  <= RST_FAST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODE:  cfg_q.mode      <= cfg_data[MODE_W-1:0];
				REG_COLOR: cfg_q.color     <= cfg_data[COLOR_W-1:0];
				REG_PULSE: cfg_q.pulse_int <= cfg_data[INTERVAL_W-1:0];
				REG_BLINK: cfg_q.blink_int <= cfg_data[INTERVAL_W-1:0];
				REG_FAST:  cfg_q.fast_int  <= cfg_data[INTERVAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/lpg_core.sv]
// Pattern state and per-tick decision of the LED pattern generator.
// Holds the tick counter, pulse ramp, blink flags and double blink phase.
// Depends on lpg_pkg for pattern codes and lpg_cfg_t.
module lpg_core
	import lpg_pkg::*;
#(
	parameter int PULSE_STEPS = 20,
	parameter int LW          = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lpg_cfg_t           cfg,
	input  logic               advance,
	input  logic               valid_s1,
	input  logic               restart_s1,
	output logic               valid_s2,
	output logic [COLOR_W-1:0] color_s2,
	output logic [LW-1:0]      level_s2
);

	typedef enum logic [4:0] {
		PH_ON_A  = 5'b00001,
		PH_OFF_A = 5'b00010,
		PH_ON_B  = 5'b00100,
		PH_OFF_B = 5'b01000,
		PH_HOLD  = 5'b10000
	} lpg_phase_t;

	localparam logic [LW-1:0] LEVEL_FULL = PULSE_STEPS[LW-1:0];
	localparam logic [LW:0]   STEPS_EXT  = PULSE_STEPS[LW:0];
	localparam logic [LW-1:0] LEVEL_ONE  = {{(LW-1){1'b0}}, 1'b1};

	logic [INTERVAL_W-1:0] elapsed_q;
	logic [LW-1:0]         level_q;
	logic                  rising_q;
	logic                  blink_q;
	logic                  fast_q;
	lpg_phase_t            phase_q;

	logic [INTERVAL_W-1:0] elapsed_b;
	logic [INTERVAL_W-1:0] elapsed_c;
	logic [INTERVAL_W-1:0] elapsed_n;
	logic [LW-1:0]         level_b;
	logic [LW-1:0]         level_n;
	logic [LW:0]           level_up;
	logic                  rising_b;
	logic                  rising_n;
	logic                  blink_n;
	logic                  fast_n;
	lpg_phase_t            phase_n;
	logic                  emit;
	logic [COLOR_W-1:0]    emit_color;
	logic [LW-1:0]         emit_level;

	// restart, tick count and pattern step for the item in stage 1
	always_comb begin
		elapsed_b  = restart_s1 ? '0 : elapsed_q;
		level_b    = restart_s1 ? '0 : level_q;
		rising_b   = restart_s1 | rising_q;
		elapsed_c  = (elapsed_b == ELAPSED_MAX) ? elapsed_b : elapsed_b + 1'b1;
		level_up   = {1'b0, level_b} + {{LW{1'b0}}, 1'b1};
		elapsed_n  = elapsed_c;
		level_n    = level_b;
		rising_n   = rising_b;
		blink_n    = blink_q;
		fast_n     = fast_q;
		phase_n    = phase_q;
		emit       = 1'b0;
		emit_color = cfg.color;
		emit_level = LEVEL_FULL;
		case (cfg.mode)
			MODE_SOLID: begin
				emit = 1'b1;
			end
			MODE_PULSE: begin
				if (elapsed_c >= cfg.pulse_int) begin
					elapsed_n = '0;
					emit      = 1'b1;
					if (rising_b) begin
						if (level_up >= STEPS_EXT) begin
							level_n  = LEVEL_FULL;
							rising_n = 1'b0;
						end else begin
							level_n = level_up[LW-1:0];
						end
					end else if (level_b <= LEVEL_ONE) begin
						level_n  = '0;
						rising_n = 1'b1;
					end else begin
						level_n = level_b - LEVEL_ONE;
					end
					emit_level = level_n;
				end
			end
			MODE_BLINK: begin
				if (elapsed_c >= cfg.blink_int) begin
					elapsed_n  = '0;
					blink_n    = ~blink_q;
					emit       = 1'b1;
					emit_color = blink_n ? cfg.color : '0;
				end
			end
			MODE_FAST: begin
				if (elapsed_c >= cfg.fast_int) begin
					elapsed_n  = '0;
					fast_n     = ~fast_q;
					emit       = 1'b1;
					emit_color = fast_n ? cfg.color : '0;
				end
			end
			MODE_DOUBLE: begin
				if (elapsed_c >= cfg.blink_int) begin
					elapsed_n = '0;
					case (phase_q)
						PH_ON_A: begin
							emit    = 1'b1;
							phase_n = PH_OFF_A;
						end
						PH_OFF_A: begin
							emit       = 1'b1;
							emit_color = '0;
							phase_n    = PH_ON_B;
						end
						PH_ON_B: begin
							emit    = 1'b1;
							phase_n = PH_OFF_B;
						end
						PH_OFF_B: begin
							emit       = 1'b1;
							emit_color = '0;
							phase_n    = PH_HOLD;
						end
						default: begin
							// hold: silent tick, then back to the first flash
							phase_n = PH_ON_A;
						end
					endcase
				end
			end
			default: begin
				// unused pattern codes only count ticks
			end
		endcase
	end

	// pattern state, moves only when a tick item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			level_q   <= '0;
			rising_q  <= 1'b1;
			blink_q   <= 1'b0;
			fast_q    <= 1'b0;
			phase_q   <= PH_ON_A;
		end else if (advance && valid_s1) begin
			elapsed_q <= elapsed_n;
			level_q   <= level_n;
			rising_q  <= rising_n;
			blink_q   <= blink_n;
			fast_q    <= fast_n;
			phase_q   <= phase_n;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && emit;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (advance) begin
			color_s2 <= emit_color;
			level_s2 <= emit_level;
		end
	end

endmodule

[rtl/lpg_dim.sv]
// Brightness scaling of the LED pattern generator: channel * level / steps.
// Stage 3 holds the products, the output register holds the quotients,
// found by an exact reciprocal multiply. Depends on lpg_pkg for widths.
module lpg_dim
	import lpg_pkg::*;
#(
	parameter int PULSE_STEPS = 20,
	parameter int LW          = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               valid_s2,
	input  logic [COLOR_W-1:0] color_s2,
	input  logic [LW-1:0]      level_s2,
	output logic               out_valid_q,
	output logic [COLOR_W-1:0] out_color_q
);

	localparam int     NCH     = COLOR_W / CHAN_W;
	localparam int     PW      = CHAN_W + LW;
	localparam int     K       = PW + LW;
	// ceil(2^K / steps); exact quotient for every product below 2^PW
	localparam longint RECIP_L = ((longint'(1) << K) + longint'(PULSE_STEPS) - 1)
	                             / longint'(PULSE_STEPS);
	localparam logic [K-1:0] RECIP = RECIP_L[K-1:0];

	logic          valid_s3;
	logic [PW-1:0] prod_s3 [NCH];

	// stage 3 and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	for (genvar i = 0; i < NCH; i++) begin : g_lane
		logic [PW-1:0]   prod;
		logic [PW+K-1:0] full;

		// channel times level
		assign prod = {{LW{1'b0}}, color_s2[i*CHAN_W +: CHAN_W]} *
		              {{CHAN_W{1'b0}}, level_s2};
		// divide by the step count
		assign full = {{K{1'b0}}, prod_s3[i]} * {{PW{1'b0}}, RECIP};

		always_ff @(posedge clk) begin
			if (advance) begin
				prod_s3[i]                      <= prod;
				out_color_q[i*CHAN_W +: CHAN_W] <= full[K +: CHAN_W];
			end
		end
	end

endmodule

[rtl/led_pattern_generator.sv]
// Top level of the LED pattern generator: input register, configuration
// registers, pattern core and scaling pipeline with the output register.
// Depends on lpg_pkg, lpg_regs, lpg_core and lpg_dim.
//
//   port group   dir   payload                     accepted when
//   s_t*         in    s_tdata[0] restart          s_tvalid && s_tready
//   m_t*         out   m_tdata red/green/blue      m_tvalid && m_tready
//   cfg_*        in    cfg_index, cfg_data         cfg_wr_en
//
// One tick item is taken every cycle while s_tready is high; a taken item
// passes the input register, pattern core, product stage and output in turn.
// Ticks that set no color leave no result. When the output holds a result
// that is not taken, every stage holds and s_tready drops.
// Reset clears all stage valids and sets the pattern state and registers to their reset values.
module led_pattern_generator
	import lpg_pkg::*;
#(
	parameter int PULSE_STEPS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [COLOR_W-1:0]    m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
	input  logic                  cfg_wr_en,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int LW = $clog2(PULSE_STEPS + 1);

	lpg_cfg_t           cfg;
	logic               advance;
	logic               valid_s1;
	logic               restart_s1;
	logic               valid_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [LW-1:0]      level_s2;
	logic               out_valid_q;
	logic [COLOR_W-1:0] out_color_q;

	// the whole pipeline moves unless a finished result is held
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			restart_s1 <= s_tdata[0];
		end
	end

	lpg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lpg_core #(
		.PULSE_STEPS (PULSE_STEPS),
		.LW          (LW)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.restart_s1 (restart_s1),
		.valid_s2   (valid_s2),
		.color_s2   (color_s2),
		.level_s2   (level_s2)
	);

	lpg_dim #(
		.PULSE_STEPS (PULSE_STEPS),
		.LW          (LW)
	) u_dim (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.valid_s2    (valid_s2),
		.color_s2    (color_s2),
		.level_s2    (level_s2),
		.out_valid_q (out_valid_q),
		.out_color_q (out_color_q)
	);

	// color register is red high; the stream carries red in the low byte
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_color_q[7:0], out_color_q[15:8], out_color_q[23:16]};

endmodule

[rtl/lpg_checker.sv]
// Port-level checks for the LED pattern generator, attached by bind.
// Depends only on the top level's ports.
module lpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a held result keeps its color
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("held result changed");

	// reset seen at the clock clears any result shown
	a_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown during reset");

	// a stalled output stops the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("item taken while output stalled");

	// an empty output never blocks the input side
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind led_pattern_generator lpg_checker u_lpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
